// ===== src/ftc_pkg.sv =====
`default_nettype none
package ftc_pkg;

    localparam int MAX_FLOWS = 64;
    localparam int ADDR_W    = 32;
    localparam int PKT_W     = 32;
    localparam int IDX_W     = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CNT_W     = $clog2(MAX_FLOWS + 1);

    // one reported flow, core to output stage
    typedef struct packed {
        logic [ADDR_W-1:0] source;
        logic [ADDR_W-1:0] destination;
        logic [PKT_W-1:0]  packets;
        logic              last;
        logic              overflowed;
    } t_flow;

endpackage
`default_nettype wire

// ===== src/ftc_core.sv =====
`default_nettype none
module ftc_core
    import ftc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ADDR_W-1:0] i_source_address,
    input  wire logic [ADDR_W-1:0] i_destination_address,
    input  wire logic              i_final_packet,
    input  wire logic              i_slot_free,
    output logic                   o_load,
    output t_flow                  o_flow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_APPEND,
        S_RPT_RD,
        S_RPT_LD
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PKT_W-1:0]  packets;
    } t_entry;

    t_entry r_mem [MAX_FLOWS];
    t_entry r_rd_data;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_used;
    logic              r_ovf;
    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic              r_final;

    logic              accept;
    logic              hit;
    logic              at_end;
    logic              full;
    logic [CNT_W-1:0]  idx_inc;
    logic [PKT_W-1:0]  pkt_inc;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // r_rd_data always holds entry r_idx while searching or loading a report
    assign hit     = (r_rd_data.src == r_src) && (r_rd_data.dst == r_dst);
    assign idx_inc = CNT_W'(r_idx) + CNT_W'(1);
    assign at_end  = (idx_inc == r_used);
    assign full    = (r_used == CNT_W'(MAX_FLOWS));
    assign pkt_inc = (r_rd_data.packets == {PKT_W{1'b1}}) ? r_rd_data.packets
                                                          : r_rd_data.packets + PKT_W'(1);

    always_comb begin
        rd_en           = 1'b0;
        rd_addr         = r_idx;
        wr_en           = 1'b0;
        wr_addr         = r_idx;
        wr_data.src     = r_src;
        wr_data.dst     = r_dst;
        wr_data.packets = pkt_inc;
        o_load          = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    wr_en = 1'b1;
                end else if (!at_end) begin
                    // keep one read in flight ahead of the compare
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_APPEND: begin
                if (!full) begin
                    wr_en           = 1'b1;
                    wr_addr         = r_used[IDX_W-1:0];
                    wr_data.packets = PKT_W'(1);
                end
            end
            S_RPT_RD: begin
                rd_en = i_slot_free;
            end
            S_RPT_LD: begin
                o_load = 1'b1;
            end
            default: begin
                o_load = 1'b0;
            end
        endcase
    end

    assign o_flow.source      = r_rd_data.src;
    assign o_flow.destination = r_rd_data.dst;
    assign o_flow.packets     = r_rd_data.packets;
    assign o_flow.last        = at_end;
    assign o_flow.overflowed  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src   <= i_source_address;
            r_dst   <= i_destination_address;
            r_final <= i_final_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_used  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_state <= (r_used == '0) ? S_APPEND : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_idx   <= '0;
                        r_state <= r_final ? S_RPT_RD : S_IDLE;
                    end else if (at_end) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_idx <= idx_inc[IDX_W-1:0];
                    end
                end
                S_APPEND: begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_used <= r_used + CNT_W'(1);
                    end
                    r_idx   <= '0;
                    r_state <= r_final ? S_RPT_RD : S_IDLE;
                end
                S_RPT_RD: begin
                    if (i_slot_free) begin
                        r_state <= S_RPT_LD;
                    end
                end
                S_RPT_LD: begin
                    if (at_end) begin
                        r_used  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= idx_inc[IDX_W-1:0];
                        r_state <= S_RPT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_FLOWS))
        else $error("flow count beyond table size");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !$past(r_ovf) && $past(i_rst_n)) |-> ($past(r_used) == CNT_W'(MAX_FLOWS)))
        else $error("overflow raised with free entries");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && o_flow.last) |=> (r_used == '0 && !r_ovf))
        else $error("table not cleared after report");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> $past(i_slot_free))
        else $error("result loaded into busy output stage");

    a_search_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_RPT_LD) |-> (CNT_W'(r_idx) < r_used))
        else $error("index outside stored flows");
`endif

endmodule
`default_nettype wire

// ===== src/flow_table_counter.sv =====
// Channel   Direction  Handshake                 Payload
// packet    in         i_in_valid / o_in_stall   source, destination, final flag
// flow      out        o_out_valid / i_out_stall source, destination, count, last, overflow
//
// A packet is accepted, then compared with the stored flows one entry at a time, limited
// by the single read port of the flow table, and counted on a hit or appended on a miss.
// A report reads each flow from the table and loads it when the output slot is free.
// Reset clears the flow count, overflow flag and output valid, not the table; the table needs no clearing.
// The packet side is stalled from acceptance until the search, append or report has finished.
// The output register holds a flow while i_out_stall is high.
`default_nettype none
module flow_table_counter
    import ftc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ADDR_W-1:0] i_source_address,
    input  wire logic [ADDR_W-1:0] i_destination_address,
    input  wire logic              i_final_packet,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ADDR_W-1:0]      o_flow_source,
    output logic [ADDR_W-1:0]      o_flow_destination,
    output logic [PKT_W-1:0]       o_flow_packets,
    output logic                   o_last_flow,
    output logic                   o_table_overflowed
);

    logic  slot_free;
    logic  load;
    t_flow flow;
    t_flow r_out;
    logic  r_out_valid;

    assign slot_free = !r_out_valid || !i_out_stall;

    ftc_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_final_packet        (i_final_packet),
        .i_slot_free           (slot_free),
        .o_load                (load),
        .o_flow                (flow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= flow;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_flow_source      = r_out.source;
    assign o_flow_destination = r_out.destination;
    assign o_flow_packets     = r_out.packets;
    assign o_last_flow        = r_out.last;
    assign o_table_overflowed = r_out.overflowed;

endmodule
`default_nettype wire
